/* src/pts_pkg.sv */
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types, register map and saturation helpers for the trapezoid
// pulse shaper.
// ----------------------------------------------------------------------------
package pts_pkg;

    // Register port geometry.
    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 5;

    // Register field widths.
    localparam int BASE_W   = 14;
    localparam int RISE_W   = 12;
    localparam int FLAT_W   = 12;
    localparam int POLE_W   = 17;
    localparam int INTEG_W  = 17;
    localparam int DIRECT_W = 16;

    // Datapath widths fixed by the result fields.
    localparam int STAGE_W   = 32;
    localparam int SUM_W     = 48;
    localparam int TAP_W     = 14;
    localparam int M_TDATA_W = SUM_W + STAGE_W;

    // Register reset values.
    localparam logic [BASE_W-1:0]   BASE_RST   = 14'd0;
    localparam logic [RISE_W-1:0]   RISE_RST   = 12'd2500;
    localparam logic [FLAT_W-1:0]   FLAT_RST   = 12'd500;
    localparam logic [POLE_W-1:0]   POLE_RST   = 17'd64951;
    localparam logic [INTEG_W-1:0]  INTEG_RST  = 17'd66847;
    localparam logic [DIRECT_W-1:0] DIRECT_RST = 16'd1245;

    // Register word index (byte address divided by four).
    typedef enum logic [2:0] {
        CFG_BASELINE = 3'd0,
        CFG_RISE     = 3'd1,
        CFG_FLAT     = 3'd2,
        CFG_POLE     = 3'd3,
        CFG_INTEG    = 3'd4,
        CFG_DIRECT   = 3'd5
    } cfg_idx_t;

    // Configuration seen by the datapath.
    typedef struct packed {
        logic [BASE_W-1:0]   baseline_level;
        logic [RISE_W-1:0]   rise_time;
        logic [FLAT_W-1:0]   flat_top;
        logic [POLE_W-1:0]   pole_recip;
        logic [INTEG_W-1:0]  integral_gain;
        logic [DIRECT_W-1:0] direct_gain;
    } pts_cfg_t;

    // Clamp a wide signed value into the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -64'sh0000_0000_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Clamp a wide signed value into the signed 48-bit range.
    function automatic logic signed [47:0] sat48(input logic signed [63:0] v);
        logic signed [47:0] r;
        if (v > 64'sh0000_7FFF_FFFF_FFFF) begin
            r = 48'sh7FFF_FFFF_FFFF;
        end else if (v < -64'sh0000_8000_0000_0000) begin
            r = 48'sh8000_0000_0000;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

endpackage

/* src/pts_delay_ram.sv */
// ----------------------------------------------------------------------------
// pts_delay_ram
// Simple dual-port delay-line memory: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module pts_delay_ram #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = 13,
    parameter int DATA_W = 32
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port with output register.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/pts_cfg_regs.sv */
// ----------------------------------------------------------------------------
// pts_cfg_regs
// APB register block holding the shaper coefficients and trapezoid lengths.
// Writes complete in the access phase; reads return the stored value.
// ----------------------------------------------------------------------------
module pts_cfg_regs (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pts_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [pts_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [pts_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output pts_pkg::pts_cfg_t                cfg
);

    pts_pkg::pts_cfg_t cfg_reg;
    pts_pkg::cfg_idx_t idx;
    logic              wr_fire;

    assign pready  = 1'b1;
    assign idx     = pts_pkg::cfg_idx_t'(paddr[pts_pkg::CFG_ADDR_W-1:2]);
    assign wr_fire = psel & penable & pwrite & pready;

    // Register writes; unknown indexes are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.baseline_level <= pts_pkg::BASE_RST;
            cfg_reg.rise_time      <= pts_pkg::RISE_RST;
            cfg_reg.flat_top       <= pts_pkg::FLAT_RST;
            cfg_reg.pole_recip     <= pts_pkg::POLE_RST;
            cfg_reg.integral_gain  <= pts_pkg::INTEG_RST;
            cfg_reg.direct_gain    <= pts_pkg::DIRECT_RST;
        end else if (wr_fire) begin
            case (idx)
                pts_pkg::CFG_BASELINE: begin
                    cfg_reg.baseline_level <= pwdata[pts_pkg::BASE_W-1:0];
                end
                pts_pkg::CFG_RISE: begin
                    cfg_reg.rise_time <= pwdata[pts_pkg::RISE_W-1:0];
                end
                pts_pkg::CFG_FLAT: begin
                    cfg_reg.flat_top <= pwdata[pts_pkg::FLAT_W-1:0];
                end
                pts_pkg::CFG_POLE: begin
                    cfg_reg.pole_recip <= pwdata[pts_pkg::POLE_W-1:0];
                end
                pts_pkg::CFG_INTEG: begin
                    cfg_reg.integral_gain <= pwdata[pts_pkg::INTEG_W-1:0];
                end
                pts_pkg::CFG_DIRECT: begin
                    cfg_reg.direct_gain <= pwdata[pts_pkg::DIRECT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read mux.
    always_comb begin
        case (idx)
            pts_pkg::CFG_BASELINE: prdata = pts_pkg::CFG_DATA_W'(cfg_reg.baseline_level);
            pts_pkg::CFG_RISE:     prdata = pts_pkg::CFG_DATA_W'(cfg_reg.rise_time);
            pts_pkg::CFG_FLAT:     prdata = pts_pkg::CFG_DATA_W'(cfg_reg.flat_top);
            pts_pkg::CFG_POLE:     prdata = pts_pkg::CFG_DATA_W'(cfg_reg.pole_recip);
            pts_pkg::CFG_INTEG:    prdata = pts_pkg::CFG_DATA_W'(cfg_reg.integral_gain);
            pts_pkg::CFG_DIRECT:   prdata = pts_pkg::CFG_DATA_W'(cfg_reg.direct_gain);
            default:               prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

/* src/pulse_trapezoid_shaper.sv */
// ----------------------------------------------------------------------------
// pulse_trapezoid_shaper
// Trapezoidal pulse shaper for a digitizer stream: 4-sample average with
// baseline removal, two recursive differentiator stages plus a direct term,
// and a trapezoid built from a delay line in block memory and an accumulator.
//
//   Channel   Direction  Beat contents
//   s_axis    in         tdata: sample; tuser: record_start
//   m_axis    out        tdata: shaped_value [47:0], diff_value [79:48]
//   apb       in/out     six 32-bit registers at byte addresses 0x00..0x14
//
// Each item passes through the steps AVG, MUL1, RND1, MUL2, RND2, MUL3, SUM
// and TRAP until its result is loaded into the output register, and a new
// beat is taken only back in IDLE: the chain of three dependent multiplies with
// their rounding steps sets the length, and the three delay-line taps are read
// one per cycle on the memory's single read port while the multiplies run.
// The item is finished before the next beat is accepted, so the memory
// write of one item never overlaps the tap reads of the next.
// Reset and record start clear the filter state; a fill count makes taps
// older than the record read zero, so the memory needs no clearing pass.
// A result that is not taken holds the block in its final step.
// ----------------------------------------------------------------------------
module pulse_trapezoid_shaper #(
    parameter int DELAY_DEPTH = 8192,
    parameter int SAMPLE_BITS = 14,
    parameter int FRAC_BITS   = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // APB register port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [pts_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [pts_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [pts_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                 pready,
    // Sample input
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,  // sample
    input  logic                                 s_axis_tuser,  // record_start
    // Result output
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [pts_pkg::M_TDATA_W-1:0]        m_axis_tdata   // shaped_value, diff_value
);

    localparam int ADDR_W  = $clog2(DELAY_DEPTH);
    localparam int CNT_W   = $clog2(DELAY_DEPTH + 1);
    localparam int CMP_W   = (CNT_W > pts_pkg::TAP_W) ? CNT_W : pts_pkg::TAP_W;
    localparam int SUM4_W  = SAMPLE_BITS + 2;
    localparam int C_PRE_W = ((SAMPLE_BITS > pts_pkg::BASE_W) ? SAMPLE_BITS
                                                               : pts_pkg::BASE_W)
                             + FRAC_BITS + 1;
    localparam int E1_W    = pts_pkg::STAGE_W + 2;
    localparam int P1_W    = E1_W + pts_pkg::POLE_W + 1;
    localparam int P2_W    = pts_pkg::INTEG_W + 1 + pts_pkg::STAGE_W;
    localparam int SH_W    = pts_pkg::STAGE_W + FRAC_BITS;
    localparam int T_PRE_W = ((SH_W > P2_W) ? SH_W : P2_W) + 2;
    localparam int T_W     = T_PRE_W - FRAC_BITS;
    localparam int P3_W    = T_W + pts_pkg::POLE_W + 1;
    localparam int PD_W    = pts_pkg::DIRECT_W + 1 + pts_pkg::STAGE_W;
    localparam int NT_W    = pts_pkg::SUM_W + 3;

    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    // Sequencer steps.
    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_AVG  = 9'b000000010,
        ST_MUL1 = 9'b000000100,
        ST_RND1 = 9'b000001000,
        ST_MUL2 = 9'b000010000,
        ST_RND2 = 9'b000100000,
        ST_MUL3 = 9'b001000000,
        ST_SUM  = 9'b010000000,
        ST_TRAP = 9'b100000000
    } state_t;

    // Round to nearest, ties toward plus infinity, dropping the fraction.
    function automatic logic signed [63:0] rnd_q(input logic signed [63:0] v);
        return (v + HALF) >>> FRAC_BITS;
    endfunction

    pts_pkg::pts_cfg_t cfg;

    state_t                     state_reg, state_next;

    // Filter state.
    logic [SAMPLE_BITS-1:0]     hist_reg [3];
    logic signed [31:0]         pc_reg;
    logic signed [31:0]         fs_reg;
    logic signed [31:0]         ss_reg;
    logic signed [47:0]         ts_reg;
    logic [ADDR_W-1:0]          wp_reg;
    logic [CNT_W-1:0]           fill_reg;

    // Per-item working registers.
    logic [SAMPLE_BITS-1:0]     sample_reg;
    logic signed [31:0]         c_reg;
    logic signed [P1_W-1:0]     p1_reg;
    logic signed [PD_W-1:0]     pd_reg;
    logic signed [31:0]         y_reg;
    logic signed [P2_W-1:0]     p2_reg;
    logic signed [T_W-1:0]      t_reg;
    logic signed [P3_W-1:0]     p3_reg;
    logic signed [31:0]         d_reg;
    logic signed [31:0]         a_reg;
    logic signed [31:0]         tap_reg [3];

    // Output register.
    logic                           m_valid_reg;
    logic [pts_pkg::M_TDATA_W-1:0]  m_data_reg;

    // Combinational datapath.
    logic [SUM4_W-1:0]          sum4;
    logic signed [C_PRE_W-1:0]  c_pre;
    logic signed [31:0]         c_next;
    logic signed [E1_W-1:0]     e1;
    logic signed [P1_W-1:0]     p1_next;
    logic signed [PD_W-1:0]     pd_next;
    logic signed [31:0]         y_next;
    logic signed [P2_W-1:0]     p2_next;
    logic signed [T_PRE_W-1:0]  t_pre;
    logic signed [63:0]         t_full;
    logic signed [T_W-1:0]      t_next;
    logic signed [P3_W-1:0]     p3_next;
    logic signed [31:0]         d_next;
    logic signed [31:0]         a_next;
    logic signed [31:0]         tap_use [3];
    logic signed [NT_W-1:0]     nt;
    logic signed [47:0]         ts_next;
    logic signed [48:0]         ts_neg;
    logic signed [47:0]         shaped;

    // Tap addressing.
    logic [pts_pkg::TAP_W-1:0]  dly_raw [3];
    logic [CNT_W-1:0]           dly [3];
    logic [CNT_W:0]             asum [3];
    logic [ADDR_W-1:0]          tap_addr [3];
    logic signed [31:0]         tap_val [3];

    // Memory port signals.
    logic                       rd_en;
    logic [ADDR_W-1:0]          rd_addr;
    logic [31:0]                rd_data;
    logic                       wr_en;

    logic                       in_fire;
    logic                       out_free;

    pts_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pts_delay_ram #(
        .DEPTH  (DELAY_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (32)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (a_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign out_free      = ~m_valid_reg | m_axis_tready;
    assign wr_en         = (state_reg == ST_TRAP) & out_free;

    // Tap delays K, K+M and 2K+M, clamped to the delay depth, and their
    // addresses behind the write pointer. A tap reaching before the start
    // of the record reads zero.
    always_comb begin
        dly_raw[0] = pts_pkg::TAP_W'(cfg.rise_time);
        dly_raw[1] = pts_pkg::TAP_W'(cfg.rise_time) + pts_pkg::TAP_W'(cfg.flat_top);
        dly_raw[2] = pts_pkg::TAP_W'(cfg.rise_time) + dly_raw[1];
        for (int i = 0; i < 3; i++) begin
            if (CMP_W'(dly_raw[i]) > CMP_W'(DELAY_DEPTH)) begin
                dly[i] = CNT_W'(DELAY_DEPTH);
            end else begin
                dly[i] = CNT_W'(dly_raw[i]);
            end
            asum[i] = (CNT_W+1)'(wp_reg) + (CNT_W+1)'(DELAY_DEPTH) - (CNT_W+1)'(dly[i]);
            if (asum[i] >= (CNT_W+1)'(DELAY_DEPTH)) begin
                asum[i] = asum[i] - (CNT_W+1)'(DELAY_DEPTH);
            end
            tap_addr[i] = asum[i][ADDR_W-1:0];
            tap_val[i]  = (dly[i] <= fill_reg) ? $signed(rd_data) : 32'sd0;
        end
    end

    // One tap read is issued per step while the multiplies run.
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = tap_addr[0];
        case (state_reg)
            ST_AVG: begin
                rd_en   = 1'b1;
                rd_addr = tap_addr[0];
            end
            ST_MUL1: begin
                rd_en   = 1'b1;
                rd_addr = tap_addr[1];
            end
            ST_RND1: begin
                rd_en   = 1'b1;
                rd_addr = tap_addr[2];
            end
            default: begin
            end
        endcase
    end

    // Arithmetic of each step.
    always_comb begin
        sum4 = SUM4_W'(sample_reg) + SUM4_W'(hist_reg[0]) + SUM4_W'(hist_reg[1])
             + SUM4_W'(hist_reg[2]);
        c_pre = $signed(C_PRE_W'(sum4) << (FRAC_BITS - 2))
              - $signed(C_PRE_W'(cfg.baseline_level) << FRAC_BITS);
        c_next = pts_pkg::sat32(64'(c_pre));

        e1      = E1_W'(fs_reg) + E1_W'(c_reg) - E1_W'(pc_reg);
        p1_next = e1 * $signed({1'b0, cfg.pole_recip});
        pd_next = $signed({1'b0, cfg.direct_gain}) * c_reg;

        y_next  = pts_pkg::sat32(rnd_q(64'(p1_reg)));
        p2_next = $signed({1'b0, cfg.integral_gain}) * y_reg;

        t_pre   = (T_PRE_W'(ss_reg) <<< FRAC_BITS) + T_PRE_W'(p2_reg)
                - (T_PRE_W'(fs_reg) <<< FRAC_BITS);
        t_full  = rnd_q(64'(t_pre));
        t_next  = t_full[T_W-1:0];
        p3_next = t_reg * $signed({1'b0, cfg.pole_recip});

        d_next  = pts_pkg::sat32(rnd_q(64'(p3_reg)));
        a_next  = pts_pkg::sat32(64'(d_next) + rnd_q(64'(pd_reg)));

        // A tap delay of zero reads the value being added.
        for (int i = 0; i < 3; i++) begin
            tap_use[i] = (dly[i] == '0) ? a_reg : tap_reg[i];
        end
        nt = NT_W'(ts_reg) + NT_W'(a_reg) - NT_W'(tap_use[0]) - NT_W'(tap_use[1])
           + NT_W'(tap_use[2]);
        ts_next = pts_pkg::sat48(64'(nt));
        ts_neg  = -(49'(ts_next));
        shaped  = pts_pkg::sat48(64'(ts_neg));
    end

    // Step sequencing.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = ST_AVG;
                end
            end
            ST_AVG:  state_next = ST_MUL1;
            ST_MUL1: state_next = ST_RND1;
            ST_RND1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_RND2;
            ST_RND2: state_next = ST_MUL3;
            ST_MUL3: state_next = ST_SUM;
            ST_SUM:  state_next = ST_TRAP;
            ST_TRAP: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and filter state; record start clears it as the beat is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            hist_reg[0] <= '0;
            hist_reg[1] <= '0;
            hist_reg[2] <= '0;
            pc_reg      <= '0;
            fs_reg      <= '0;
            ss_reg      <= '0;
            ts_reg      <= '0;
            wp_reg      <= '0;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (in_fire && s_axis_tuser) begin
                hist_reg[0] <= '0;
                hist_reg[1] <= '0;
                hist_reg[2] <= '0;
                pc_reg      <= '0;
                fs_reg      <= '0;
                ss_reg      <= '0;
                ts_reg      <= '0;
                wp_reg      <= '0;
                fill_reg    <= '0;
            end else if (wr_en) begin
                hist_reg[2] <= hist_reg[1];
                hist_reg[1] <= hist_reg[0];
                hist_reg[0] <= sample_reg;
                pc_reg      <= c_reg;
                fs_reg      <= y_reg;
                ss_reg      <= d_reg;
                ts_reg      <= ts_next;
                if (wp_reg == ADDR_W'(DELAY_DEPTH - 1)) begin
                    wp_reg <= '0;
                end else begin
                    wp_reg <= wp_reg + 1'b1;
                end
                if (fill_reg != CNT_W'(DELAY_DEPTH)) begin
                    fill_reg <= fill_reg + 1'b1;
                end
            end
            if (wr_en) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers, each loaded in its own step.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            sample_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
        if (state_reg == ST_AVG) begin
            c_reg <= c_next;
        end
        if (state_reg == ST_MUL1) begin
            p1_reg     <= p1_next;
            pd_reg     <= pd_next;
            tap_reg[0] <= tap_val[0];
        end
        if (state_reg == ST_RND1) begin
            y_reg      <= y_next;
            tap_reg[1] <= tap_val[1];
        end
        if (state_reg == ST_MUL2) begin
            p2_reg     <= p2_next;
            tap_reg[2] <= tap_val[2];
        end
        if (state_reg == ST_RND2) begin
            t_reg <= t_next;
        end
        if (state_reg == ST_MUL3) begin
            p3_reg <= p3_next;
        end
        if (state_reg == ST_SUM) begin
            d_reg <= d_next;
            a_reg <= a_next;
        end
        if (wr_en) begin
            m_data_reg <= {d_reg, shaped};
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule
